// File: src/stld_pkg.sv
package stld_pkg;

	// little-endian length field size in bytes, 1 to 4
	localparam int LEN_BYTES = 4;
	localparam int CNT_W     = 3;
	localparam int CFG_AW    = 3;
	localparam logic [31:0] SYNC_WORD_RESET = 32'h524B_444D;

	// word index taken from paddr[2]
	localparam logic REG_SYNC_WORD = 1'b0;

	typedef enum logic [6:0] {
		PH_SYNC0 = 7'b000_0001,
		PH_SYNC1 = 7'b000_0010,
		PH_SYNC2 = 7'b000_0100,
		PH_SYNC3 = 7'b000_1000,
		PH_TYPE  = 7'b001_0000,
		PH_LEN   = 7'b010_0000,
		PH_DATA  = 7'b100_0000
	} phase_t;

endpackage

// File: src/sync_type_length_deframer_unit.sv
// an accepted byte is held in the input register, then its item in the result register
// throughput: one item per cycle, set by the single input register and result register
// a stalled output only blocks input once the input register is also full
// reset (arst_n low, asynchronous): hunt restarts at the first sync byte,
// sync_word returns to 0x524B444D, both pipeline registers empty
module sync_type_length_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [stld_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    payload_byte,
	output logic [7:0]                    frame_type,
	output logic                          is_last,
	output logic                          empty_frame
);
	import stld_pkg::*;

	logic [31:0]      sync_word_q;
	phase_t           phase_q, phase_d;
	logic [7:0]       held_type_q, held_type_d;
	logic [31:0]      frame_length_q, frame_length_d;
	logic [CNT_W-1:0] len_seen_q, len_seen_d;
	logic [31:0]      payload_count_q, payload_count_d;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	logic             out_valid_s2;
	logic [7:0]       payload_s2;
	logic [7:0]       type_s2;
	logic             last_s2;
	logic             empty_s2;

	logic             res_valid;
	logic [7:0]       res_byte;
	logic             res_last;
	logic             res_empty;
	logic [31:0]      len_acc;
	logic [CNT_W-1:0] len_seen_inc;
	logic [31:0]      count_inc;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SYNC_WORD) ? sync_word_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_WORD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_SYNC_WORD) begin
			sync_word_q <= pwdata;
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame parsing
	assign len_acc      = frame_length_q | (32'(byte_s1) << {len_seen_q[1:0], 3'b000});
	assign len_seen_inc = len_seen_q + CNT_W'(1);
	assign count_inc    = payload_count_q + 32'd1;

	always_comb begin
		phase_d         = phase_q;
		held_type_d     = held_type_q;
		frame_length_d  = frame_length_q;
		len_seen_d      = len_seen_q;
		payload_count_d = payload_count_q;
		res_valid       = 1'b0;
		res_byte        = 8'd0;
		res_last        = 1'b0;
		res_empty       = 1'b0;
		unique case (phase_q)
			PH_SYNC1: begin
				phase_d = (byte_s1 == sync_word_q[23:16]) ? PH_SYNC2 : PH_SYNC0;
			end
			PH_SYNC2: begin
				phase_d = (byte_s1 == sync_word_q[15:8]) ? PH_SYNC3 : PH_SYNC0;
			end
			PH_SYNC3: begin
				phase_d = (byte_s1 == sync_word_q[7:0]) ? PH_TYPE : PH_SYNC0;
			end
			PH_TYPE: begin
				held_type_d    = byte_s1;
				frame_length_d = 32'd0;
				len_seen_d     = '0;
				phase_d        = PH_LEN;
			end
			PH_LEN: begin
				frame_length_d = len_acc;
				len_seen_d     = len_seen_inc;
				if (len_seen_inc >= CNT_W'(LEN_BYTES)) begin
					if (len_acc == 32'd0) begin
						phase_d   = PH_SYNC0;
						res_valid = 1'b1;
						res_last  = 1'b1;
						res_empty = 1'b1;
					end else begin
						payload_count_d = 32'd0;
						phase_d         = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				payload_count_d = count_inc;
				res_valid       = 1'b1;
				res_byte        = byte_s1;
				if (count_inc == frame_length_q) begin
					res_last = 1'b1;
					phase_d  = PH_SYNC0;
				end
			end
			default: begin
				// first sync byte, also any stray code
				phase_d = (byte_s1 == sync_word_q[31:24]) ? PH_SYNC1 : PH_SYNC0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SYNC0;
			held_type_q     <= 8'd0;
			frame_length_q  <= 32'd0;
			len_seen_q      <= '0;
			payload_count_q <= 32'd0;
		end else if (advance) begin
			phase_q         <= phase_d;
			held_type_q     <= held_type_d;
			frame_length_q  <= frame_length_d;
			len_seen_q      <= len_seen_d;
			payload_count_q <= payload_count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= res_valid;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			payload_s2 <= res_byte;
			type_s2    <= held_type_q;
			last_s2    <= res_last;
			empty_s2   <= res_empty;
		end
	end

	assign out_valid    = out_valid_s2;
	assign payload_byte = payload_s2;
	assign frame_type   = type_s2;
	assign is_last      = last_s2;
	assign empty_frame  = empty_s2;

endmodule

// File: src/stld_checker.sv
module stld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] payload_byte,
	input logic [7:0] frame_type,
	input logic       is_last,
	input logic       empty_frame
);

	// a stalled result keeps its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_type)
			&& $stable(is_last) && $stable(empty_frame))
		else $error("result changed while stalled");

	// an empty frame is a single closing item with a zero byte
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_frame |-> is_last && payload_byte == 8'd0)
		else $error("empty frame item malformed");

	// input back-pressure only comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind sync_type_length_deframer_unit stld_checker u_stld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.payload_byte (payload_byte),
	.frame_type   (frame_type),
	.is_last      (is_last),
	.empty_frame  (empty_frame)
);

// File: verif/tb_top.sv
module tb_top;
	import stld_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] ftype;
		logic       last;
		logic       empty;
	} deframed_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        payload_byte;
	logic [7:0]        frame_type;
	logic              is_last;
	logic              empty_frame;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int sent_items;

	// shadow copy of the deframer state
	phase_t      rx_phase;
	logic [31:0] sync_reg;
	logic [7:0]  type_hold;
	logic [31:0] len_acc;
	logic [2:0]  len_seen;
	logic [31:0] data_seen;
	deframed_t   due_items[$];

	sync_type_length_deframer_unit dut (.*);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 30)
			$display("%0t: %s", $time, what);
	endtask

	function automatic logic [7:0] sync_at(input int k);
		return sync_reg[(31 - 8 * k) -: 8];
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		logic fin;
		case (rx_phase)
		PH_SYNC1: rx_phase = (b == sync_at(1)) ? PH_SYNC2 : PH_SYNC0;
		PH_SYNC2: rx_phase = (b == sync_at(2)) ? PH_SYNC3 : PH_SYNC0;
		PH_SYNC3: rx_phase = (b == sync_at(3)) ? PH_TYPE : PH_SYNC0;
		PH_TYPE: begin
			type_hold = b;
			len_acc = '0;
			len_seen = '0;
			rx_phase = PH_LEN;
		end
		PH_LEN: begin
			len_acc |= 32'(b) << (8 * len_seen[1:0]);
			len_seen = len_seen + 3'd1;
			if (len_seen >= LEN_BYTES) begin
				if (len_acc == 0) begin
					rx_phase = PH_SYNC0;
					due_items.push_back('{data: 8'h00, ftype: type_hold, last: 1'b1,
						empty: 1'b1});
				end else begin
					data_seen = '0;
					rx_phase = PH_DATA;
				end
			end
		end
		PH_DATA: begin
			data_seen = data_seen + 32'd1;
			fin = (data_seen == len_acc);
			if (fin)
				rx_phase = PH_SYNC0;
			due_items.push_back('{data: b, ftype: type_hold, last: fin, empty: 1'b0});
		end
		default: rx_phase = (b == sync_at(0)) ? PH_SYNC1 : PH_SYNC0;
		endcase
	endtask

	// entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_items.size() != 0)
			@(negedge clk);
	endtask

	// sync bytes give no result, so allow for items still inside the block
	task automatic wait_idle();
		wait_drained();
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_SYNC_WORD)
			sync_reg = data;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read(input logic [CFG_AW-1:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("read addr %0d: got %08h want %08h", addr, prdata, want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// break any partial sync so the next frame starts clean
	task automatic to_hunt();
		while (rx_phase != PH_SYNC0) begin
			case (rx_phase)
			PH_SYNC1: send_byte(~sync_at(1));
			PH_SYNC2: send_byte(~sync_at(2));
			PH_SYNC3: send_byte(~sync_at(3));
			default: send_byte(8'h00);
			endcase
		end
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len,
			input int fill = -1, input int first_sync = 0);
		if (first_sync == 0)
			to_hunt();
		for (int k = first_sync; k < 4; k++)
			send_byte(sync_at(k));
		send_byte(ftype);
		for (int k = 0; k < LEN_BYTES; k++)
			send_byte(len[8 * k +: 8]);
		for (int unsigned k = 0; k < len; k++)
			send_byte((fill >= 0) ? 8'(fill) : 8'($urandom_range(255)));
	endtask

	// line noise that never completes a sync word
	task automatic send_noise(input int n);
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			b = 8'($urandom_range(255));
			if (rx_phase == PH_SYNC3 && b == sync_at(3))
				b = ~b;
			send_byte(b);
		end
	endtask

	task automatic send_broken();
		logic [7:0] b;
		int depth;
		to_hunt();
		depth = $urandom_range(1, 3);
		for (int k = 0; k < depth; k++)
			send_byte(sync_at(k));
		b = 8'($urandom_range(255));
		if (b == sync_at(depth))
			b = ~b;
		send_byte(b);
	endtask

	task automatic test_reset_values();
		apb_read(3'd0, SYNC_WORD_RESET);
	endtask

	task automatic test_directed();
		send_frame(8'hFF, 32'd0);
		send_frame(8'h00, 32'd1, 8'hFF);
		// a repeated first sync byte mismatches and is not taken as a new start
		to_hunt();
		send_byte(sync_at(0));
		send_byte(sync_at(0));
		send_byte(sync_at(1));
		send_byte(sync_at(2));
		send_byte(sync_at(3));
	endtask

	task automatic test_sync_change();
		to_hunt();
		send_byte(sync_at(0));
		send_byte(sync_at(1));
		wait_idle();
		// hunt stays two bytes in, the rest compares against the new word
		apb_write(3'd0, 32'hA5C3_0F96);
		apb_read(3'd0, 32'hA5C3_0F96);
		apb_write(3'd4, 32'h1234_5678);
		apb_read(3'd0, 32'hA5C3_0F96);
		send_frame(8'h5A, 32'd3, -1, 2);
	endtask

	task automatic test_long_frame();
		send_frame(8'($urandom_range(255)), 32'd256);
	endtask

	task automatic test_random(input int sidle, input int ridle, input logic [31:0] word,
			input int target);
		int start;
		int iter;
		int pick;
		int sel;
		logic [31:0] len;
		wait_idle();
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		apb_write(3'd0, word);
		apb_read(3'd0, word);
		start = sent_items;
		iter = 0;
		while (sent_items - start < target) begin
			iter++;
			if (iter % 16 == 0)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 72) begin
				sel = $urandom_range(99);
				if (sel < 10)
					len = 32'd0;
				else if (sel < 99)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(256, 300);
				send_frame(8'($urandom_range(255)), len);
			end else if (pick < 86) begin
				send_noise($urandom_range(1, 6));
			end else begin
				send_broken();
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		deframed_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_items.size() == 0) begin
				report_mismatch($sformatf("unexpected item, byte %02h", payload_byte));
			end else begin
				want = due_items.pop_front();
				if (payload_byte !== want.data)
					report_mismatch($sformatf("payload_byte %02h want %02h",
						payload_byte, want.data));
				if (frame_type !== want.ftype)
					report_mismatch($sformatf("frame_type %02h want %02h",
						frame_type, want.ftype));
				if (is_last !== want.last)
					report_mismatch($sformatf("is_last %b want %b", is_last, want.last));
				if (empty_frame !== want.empty)
					report_mismatch($sformatf("empty_frame %b want %b",
						empty_frame, want.empty));
			end
		end
	end

	initial begin
		#3000000;
		$display("sync_type_length_deframer_unit test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 70;
		mismatch_count = 0;
		sent_items = 0;
		rx_phase = PH_SYNC0;
		sync_reg = SYNC_WORD_RESET;
		type_hold = '0;
		len_acc = '0;
		len_seen = '0;
		data_seen = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_values();
		test_directed();
		test_sync_change();
		test_long_frame();
		test_random(12, 70, 32'h0000_0000, 440);
		test_random(70, 12, 32'hFFFF_FFFF, 440);
		test_random(0, 0, $urandom, 440);
		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("sync_type_length_deframer_unit test passed");
		else
			$display("sync_type_length_deframer_unit test failed");
		$finish;
	end

endmodule

// File: files.f
src/stld_pkg.sv
src/sync_type_length_deframer_unit.sv
src/stld_checker.sv
verif/tb_top.sv
